// File: rtl/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

    // per-cycle commands from the sequencer to every cell of the row
    typedef struct packed {
        logic shift_en;   // take the neighbor's sample, a new item enters at cell 0
        logic clr;        // zero the rank counter before a median pass
        logic cmp_en;     // compare against the broadcast sample this cycle
    } cell_ctrl_t;

endpackage

// File: rtl/rmf_cell.sv
`timescale 1ns / 1ps

module rmf_cell
    import rmf_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int IDX_W        = 4,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic [SAMPLE_WIDTH-1:0] shift_in,
    input  logic [SAMPLE_WIDTH-1:0] bcast_val,
    input  logic [IDX_W-1:0]        bcast_idx,
    input  logic [IDX_W-1:0]        hi,
    input  logic [IDX_W-1:0]        tgt,
    output logic [SAMPLE_WIDTH-1:0] sample_out,
    output logic                    hit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [IDX_W-1:0]        rank_reg;
    logic [IDX_W-1:0]        rank_next;
    logic                    in_rng;
    logic                    below;

    assign in_rng = (MY_IDX <= hi);

    // ties are broken by position so the ranks form a permutation
    assign below = ($signed(bcast_val) < $signed(sample_reg)) ||
                   ((bcast_val == sample_reg) && (bcast_idx < MY_IDX));

    always_comb begin
        rank_next = rank_reg;
        if (ctrl.clr) begin
            rank_next = '0;
        end else if (ctrl.cmp_en && in_rng && below) begin
            rank_next = rank_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            sample_reg <= shift_in;
        end
        rank_reg <= rank_next;
    end

    assign sample_out = sample_reg;
    assign hit        = in_rng && (rank_reg == tgt);

endmodule

// File: rtl/running_median_filter_top.sv
`timescale 1ns / 1ps
// channel   | direction | handshake          | payload
// s_        | in        | s_tvalid/s_tready  | s_tdata: sample, s_tlast: last
// m_        | out       | m_tvalid/m_tready  | m_tdata: filtered, m_tlast: last_res
// cfg_      | in        | cfg_valid/cfg_ready| cfg_data: half_window
//
// a computed item goes from its accept through the setup state, the rank-compare states that broadcast
// the window (indices 0 to hi, hi = last window index, at most 2*MAX_HALF) along the cell row, and
// the emit state into the output register; each further flush result repeats setup, rank and emit.
// an item whose window is not yet full gives no result; a last item gives min(h, count-1)+1
// results. aresetn clears control, counts and half_window (to 1).
// the output register holds a result while m_tready is low; the sequencer waits on it.

module running_median_filter_top
    import rmf_pkg::*;
#(
    parameter int MAX_HALF     = 7,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_tdata,   // [SAMPLE_WIDTH-1:0] sample, rest zero
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_tdata,   // [SAMPLE_WIDTH-1:0] filtered, rest zero
    output logic                                   m_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [2:0]                             cfg_data
);

    localparam int DEPTH  = 2 * MAX_HALF + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HALF_W = $clog2(MAX_HALF + 1);
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_RANK  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [2:0]              half_reg;
    logic [HALF_W-1:0]       act_reg, act_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [HALF_W-1:0]       d_reg, d_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic                    last_reg, last_next;
    logic                    m_tvalid_reg;
    logic                    m_tlast_reg;
    logic [SAMPLE_WIDTH-1:0] m_data_reg;

    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic [HALF_W-1:0]       act_h;
    logic [HALF_W-1:0]       cfg_half;
    logic [CNT_W-1:0]        cnt_inc;
    logic [IDX_W-1:0]        cnt_m1;
    logic [IDX_W-1:0]        span;
    logic [IDX_W-1:0]        hi;
    logic [IDX_W-1:0]        tgt;
    logic [SAMPLE_WIDTH-1:0] bcast_val;
    logic [SAMPLE_WIDTH-1:0] sel_val;
    cell_ctrl_t              ctrl;

    logic [SAMPLE_WIDTH-1:0] cell_sample [DEPTH];
    logic [DEPTH-1:0]        cell_hit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == S_EMIT) && out_free;

    assign cfg_half = (int'(half_reg) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(half_reg);
    // h is latched on the first item of a stream
    assign act_h    = (count_reg == '0) ? cfg_half : act_reg;
    assign cnt_inc  = (int'(count_reg) < DEPTH) ? count_reg + CNT_W'(1) : count_reg;

    // window of center d runs from index 0 (d never exceeds h) to min(d+h, count-1)
    assign cnt_m1 = IDX_W'(count_reg - CNT_W'(1));
    assign span   = IDX_W'(d_reg) + IDX_W'(act_reg);
    assign hi     = (span < cnt_m1) ? span : cnt_m1;
    assign tgt    = (hi >> 1) + IDX_W'(hi[0]);

    assign ctrl.shift_en = accept;
    assign ctrl.clr      = (state_reg == S_SETUP);
    assign ctrl.cmp_en   = (state_reg == S_RANK);

    assign bcast_val = cell_sample[j_reg];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [SAMPLE_WIDTH-1:0] from_left;
            if (gi == 0) begin : g_head
                assign from_left = s_tdata[SAMPLE_WIDTH-1:0];
            end else begin : g_body
                assign from_left = cell_sample[gi-1];
            end
            rmf_cell #(
                .IDX          (gi),
                .IDX_W        (IDX_W),
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .shift_in   (from_left),
                .bcast_val  (bcast_val),
                .bcast_idx  (j_reg),
                .hi         (hi),
                .tgt        (tgt),
                .sample_out (cell_sample[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    // exactly one in-range cell holds the target rank
    always_comb begin
        sel_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (cell_hit[k]) begin
                sel_val = sel_val | cell_sample[k];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        count_next = count_reg;
        d_next     = d_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    count_next = cnt_inc;
                    act_next   = act_h;
                    last_next  = s_tlast;
                    if (s_tlast) begin
                        d_next     = (CNT_W'(act_h) > cnt_inc - CNT_W'(1)) ?
                                     HALF_W'(cnt_inc - CNT_W'(1)) : act_h;
                        state_next = S_SETUP;
                    end else if (cnt_inc > CNT_W'(act_h)) begin
                        d_next     = act_h;
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                j_next     = '0;
                state_next = S_RANK;
            end
            S_RANK: begin
                if (j_reg == hi) begin
                    state_next = S_EMIT;
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (last_reg && (d_reg != '0)) begin
                        d_next     = d_reg - HALF_W'(1);
                        state_next = S_SETUP;
                    end else begin
                        if (last_reg) begin
                            count_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            half_reg     <= 3'd1;
            act_reg      <= HALF_W'(1);
            count_reg    <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            act_reg   <= act_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            if (cfg_valid && cfg_ready) begin
                half_reg <= cfg_data;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        d_reg <= d_next;
        j_reg <= j_next;
        if (load_out) begin
            m_data_reg  <= sel_val;
            m_tlast_reg <= last_reg && (d_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_data_reg);
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/rmf_checker.sv
`timescale 1ns / 1ps

module rmf_checker #(
    parameter int DATA_W = 32
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast
);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // the end of a stream always starts a flush, so input closes right after it
    a_flush_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after a last item");

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind running_median_filter_top rmf_checker #(.DATA_W(DATA_W)) u_rmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int MAX_HALF     = 7;
    localparam int WIN_DEPTH    = 2 * MAX_HALF + 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TARGET_ITEMS = 270;

    typedef struct {
        logic [31:0] value;
        logic        last_res;
    } median_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [31:0] sample
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] filtered
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data  = '0;

    // predictor state
    logic signed [31:0] history [WIN_DEPTH];   // newest at index 0
    int unsigned        held_count = 0;
    int unsigned        stream_half = 1;
    logic [2:0]         half_reg = 3'd1;
    median_t            median_q [$];

    int  fail_count = 0;
    int  item_count = 0;
    int  cycle_count = 0;
    int  rx_hold = 0;
    bit  no_gaps = 1'b0;
    median_t seen;

    running_median_filter_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL running_median_filter_top");
            $finish;
        end
    end

    // median of the window centred on history[centre], cut to the held samples
    function automatic logic [31:0] window_median(input int unsigned centre);
        logic signed [31:0] sorted [WIN_DEPTH];
        logic signed [31:0] v;
        int unsigned lo, hi, len, j, k;
        lo  = (centre > stream_half) ? centre - stream_half : 0;
        hi  = centre + stream_half;
        len = 0;
        if (hi > held_count - 1) hi = held_count - 1;
        if (hi > WIN_DEPTH - 1) hi = WIN_DEPTH - 1;
        for (k = lo; k <= hi; k++) begin
            v = history[k];
            j = len;
            while (j > 0 && sorted[j - 1] > v) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
            len++;
        end
        return sorted[len / 2];
    endfunction

    function automatic void predict_medians(input logic [31:0] value, input logic is_last);
        int unsigned k, d, first;
        median_t r;
        if (held_count == 0)
            stream_half = (half_reg > MAX_HALF) ? MAX_HALF : half_reg;
        for (k = WIN_DEPTH - 1; k > 0; k--)
            history[k] = history[k - 1];
        history[0] = value;
        if (held_count < WIN_DEPTH) held_count++;
        if (!is_last) begin
            if (held_count > stream_half) begin
                r.value    = window_median(stream_half);
                r.last_res = 1'b0;
                median_q.insert(median_q.size(), r);
            end
        end else begin
            // flush: the tail samples get their cut windows, oldest first
            first = (stream_half > held_count - 1) ? held_count - 1 : stream_half;
            for (d = first + 1; d > 0; d--) begin
                r.value    = window_median(d - 1);
                r.last_res = (d == 1);
                median_q.insert(median_q.size(), r);
            end
            held_count = 0;
        end
    endfunction

    function automatic logic [31:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_sample(input logic [31:0] value, input logic is_last);
        int  gap;
        logic ok;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        predict_medians(value, is_last);
        item_count++;
    endtask

    // returns at a rising edge once nothing is outstanding and the block has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (median_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_half_window(input logic [2:0] value);
        logic ok;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(negedge aclk);
            ok = cfg_ready;
            @(posedge aclk);
        end while (!ok);
        cfg_valid <= 1'b0;
        half_reg = value;
    endtask

    task automatic send_stream(input int len);
        int i;
        for (i = 0; i < len; i++)
            push_sample(draw_sample(), i == len - 1);
    endtask

    // receiver: random stalls per item, or a long hold when one is requested
    initial begin
        int  stall;
        logic got;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid;
                @(posedge aclk);
            end while (!got);
        end
    end

    // result checker, sampled mid-cycle so the handshake seen is the one taken at the next edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (median_q.size() == 0) begin
                $error("unexpected result filtered=%0d last_res=%0b", $signed(m_tdata), m_tlast);
                fail_count++;
            end else begin
                seen = median_q.pop_front();
                if (m_tdata !== seen.value) begin
                    $error("filtered: expected %0d, got %0d",
                           $signed(seen.value), $signed(m_tdata));
                    fail_count++;
                end
                if (m_tlast !== seen.last_res) begin
                    $error("last_res: expected %0b, got %0b", seen.last_res, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // default half window of one, extremes of the sample range
    task automatic test_reset_default();
        push_sample(32'h7fff_ffff, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'hffff_ffff, 1'b0);
        push_sample(32'h0000_0001, 1'b1);
    endtask

    // one-item stream gives its own sample back, marked last
    task automatic test_single_item();
        wait_drained();
        push_sample(32'h8000_0000, 1'b1);
    endtask

    // stream shorter than h+1 holds everything back until last; h of zero passes through
    task automatic test_short_streams();
        write_half_window(3'd7);
        push_sample(32'h0000_0005, 1'b0);
        push_sample(32'hffff_fffb, 1'b0);
        push_sample(32'h7fff_ffff, 1'b1);
        write_half_window(3'd0);
        push_sample(32'h1234_5678, 1'b0);
        push_sample(32'hedcb_a987, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b1);
    endtask

    // new half window written mid-stream only applies to the next stream;
    // the sender also waits here for all results before going on
    task automatic test_mid_stream_config();
        int i;
        write_half_window(3'd2);
        for (i = 0; i < 6; i++)
            push_sample(draw_sample(), 1'b0);
        write_half_window(3'd5);
        for (i = 0; i < 4; i++)
            push_sample(draw_sample(), i == 3);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        write_half_window(3'd3);
        no_gaps = 1'b1;
        rx_hold = 400;
        send_stream(30);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_streams();
        logic [2:0] h;
        int len;
        while (item_count < TARGET_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       h = 3'd0;
                1:       h = 3'd7;
                default: h = 3'($urandom_range(0, 7));
            endcase
            if ($urandom_range(0, 2) == 0)
                write_half_window(h);
            no_gaps = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 40);
            send_stream(len);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_default();
        test_single_item();
        test_short_streams();
        test_mid_stream_config();
        test_backpressure();
        test_random_streams();
        wait_drained();
        if (fail_count == 0 && median_q.size() == 0) begin
            $display("PASS running_median_filter_top");
        end else begin
            $display("FAIL running_median_filter_top");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/rmf_pkg.sv
rtl/rmf_cell.sv
rtl/running_median_filter_top.sv
rtl/rmf_checker.sv
sim/tb.sv
